// ===== rtl/core/sbac_pkg.sv =====
// sbac_pkg: shared types and constants of the shadow bitmap access checker.
// No dependencies; every other file of the block imports it.
`default_nettype none

package sbac_pkg;

  // Field widths of the item, result and configuration channels
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 19;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shadow geometry: one bit per granule, WORD_BITS granules per shadow word
  localparam int GRANULE_BYTES = 8;
  localparam int WORD_BITS     = 32;
  localparam int GRAN_SH       = $clog2(GRANULE_BYTES);
  localparam int BIT_W         = $clog2(WORD_BITS);

  // Register sets are provided for two regions
  localparam int NREG = 2;

  // Widest granule offset inside a region (65536 words of 32 granules)
  localparam int G_MAX_W = 21;
  // Granule count of a range
  localparam int NCNT_W  = LEN_W - GRAN_SH;

  // Front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD     = 2'd0,
    FN_STORE    = 2'd1,
    FN_POISON   = 2'd2,
    FN_UNPOISON = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_HIT      = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_BASE = 3'd0,
    REG_R0_SIZE = 3'd1,
    REG_R1_BASE = 3'd2,
    REG_R1_SIZE = 3'd3,
    REG_LOAD_EN = 3'd4
  } cfg_reg_t;

  // What the back part has to do with a classified item
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_READ,
    ACT_WALK
  } act_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHECK,
    BK_WALK
  } back_state_t;

  typedef struct packed {
    func_t               func;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    status_t             status;
    act_t                act;
    logic                region;
    logic [G_MAX_W-1:0]  gran;   // region-relative granule (probe or range start)
    logic [NCNT_W-1:0]   count;  // granules in the range
  } item_t;

  typedef struct packed {
    status_t             status;
    logic                is_store;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
  } result_t;

  // Region windows as seen by the front part; lim is base plus clamped size
  typedef struct packed {
    logic [NREG-1:0][ADDR_W-1:0] base;
    logic [NREG-1:0][ADDR_W:0]   lim;
    logic [NREG-1:0]             on;
    logic                        load_en;
  } region_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbac_ifs.sv =====
// Channel interfaces of the shadow bitmap access checker: item in, result out,
// configuration write. Depends on sbac_pkg.
`default_nettype none

interface sbac_req_if import sbac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output func, output address, output length, input ready);
  modport sink   (input valid, input func, input address, input length, output ready);
endinterface

interface sbac_rsp_if import sbac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                is_store;
  logic [ADDR_W-1:0]   fault_address;
  logic [LEN_W-1:0]    fault_length;

  modport source (output valid, output status, output is_store, output fault_address,
                  output fault_length, input ready);
  modport sink   (input valid, input status, input is_store, input fault_address,
                  input fault_length, output ready);
endinterface

interface sbac_cfg_if import sbac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sbac_front.sv =====
// sbac_front: accepts items, computes the probe address and classifies each
// item against the region windows. Depends on sbac_pkg and sbac_ifs.
`default_nettype none

module sbac_front import sbac_pkg::*; #(
  parameter int REGIONS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  region_cfg_t regions,
  sbac_req_if.sink    req,
  output logic        push_valid,
  output item_t       push_item,
  input  logic        push_ready
);

  logic              accept;
  func_t             in_func;
  logic [ADDR_W-1:0] probe_in;

  logic              s1_valid;
  func_t             s1_func;
  logic [ADDR_W-1:0] s1_addr;
  logic [LEN_W-1:0]  s1_len;
  logic [ADDR_W-1:0] s1_probe;   // last byte for checks, start for ranges
  logic [ADDR_W:0]   s1_rend;    // start + length, no wrap

  logic [NREG-1:0]   hit;
  logic              sel;
  logic [ADDR_W-1:0] off;
  logic [NCNT_W-1:0] cnt;

  assign in_func   = func_t'(req.func);
  assign req.ready = enable && (!s1_valid || push_ready);
  assign accept    = req.valid && req.ready;

  assign probe_in = (in_func == FN_LOAD || in_func == FN_STORE)
                  ? req.address + ADDR_W'(req.length) - ADDR_W'(1)
                  : req.address;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func  <= in_func;
      s1_addr  <= req.address;
      s1_len   <= req.length;
      s1_probe <= probe_in;
      s1_rend  <= (ADDR_W+1)'(req.address) + (ADDR_W+1)'(req.length);
    end
  end

  // First matching region wins
  always_comb begin
    for (int r = 0; r < NREG; r++) begin
      hit[r] = (r < REGIONS) && regions.on[r] && (s1_probe >= regions.base[r])
               && ({1'b0, s1_probe} < regions.lim[r]);
    end
    sel = !hit[0];
    off = s1_probe - regions.base[sel];
    cnt = NCNT_W'(s1_len >> GRAN_SH);

    push_item.func   = s1_func;
    push_item.addr   = s1_addr;
    push_item.len    = s1_len;
    push_item.status = ST_OK;
    push_item.act    = ACT_NONE;
    push_item.region = sel;
    push_item.gran   = G_MAX_W'(off >> GRAN_SH);
    push_item.count  = cnt;

    if (s1_func == FN_LOAD || s1_func == FN_STORE) begin
      // Outside every region, or a disabled load: pass without a read
      if (hit != '0 && (s1_func == FN_STORE || regions.load_en)) begin
        push_item.act = ACT_READ;
      end
    end else if (hit == '0) begin
      push_item.status = ST_OUTSIDE;
    end else if (s1_rend > regions.lim[sel]) begin
      push_item.status = ST_PAST_END;
    end else if (cnt != '0) begin
      push_item.act = ACT_WALK;
    end
  end

  assign push_valid = s1_valid;

endmodule

`default_nettype wire

// ===== rtl/core/sbac_queue.sv =====
// sbac_queue: short FIFO of classified items between front and back part.
// Depends on sbac_pkg.
`default_nettype none

module sbac_queue import sbac_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  output item_t out_item,
  input  logic  out_pop
);

  item_t             slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   cnt;
  logic              push;

  assign in_ready  = (cnt != (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (cnt != '0);
  assign out_item  = slot[rptr];
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (out_pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !out_pop) begin
        cnt <= cnt + (QPTR_W+1)'(1);
      end else if (out_pop && !push) begin
        cnt <= cnt - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbac_back.sv =====
// sbac_back: shadow memory, clearing pass, check reads and range walks,
// and the result register. Depends on sbac_pkg and sbac_ifs.
`default_nettype none

module sbac_back import sbac_pkg::*; #(
  parameter int REGIONS                 = 2,
  parameter int SHADOW_WORDS_PER_REGION = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        clearing,
  sbac_rsp_if.source  rsp
);

  localparam int DEPTH = REGIONS * SHADOW_WORDS_PER_REGION;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(SHADOW_WORDS_PER_REGION);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  back_state_t          state;
  back_state_t          state_next;
  logic [AW-1:0]        clr_addr;

  item_t                hold;
  logic [WW-1:0]        w_cur;
  logic [WW-1:0]        w_first;
  logic [WW-1:0]        w_last;
  logic [BIT_W-1:0]     b_first;
  logic [BIT_W-1:0]     b_last;
  logic                 issued_all;
  logic                 p_valid;
  logic [WW-1:0]        p_word;
  logic [G_MAX_W:0]     gl_wide;

  logic                 res_valid;
  result_t              res;
  logic                 res_free;
  logic                 emit;
  status_t              emit_status;
  item_t                emit_src;

  logic [BIT_W-1:0]     m_lo;
  logic [BIT_W-1:0]     m_hi;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;

  function automatic logic [AW-1:0] phys(input logic region, input logic [WW-1:0] word);
    phys = (region ? AW'(SHADOW_WORDS_PER_REGION) : AW'(0)) + AW'(word);
  endfunction

  assign clearing = (state == BK_CLEAR);
  assign res_free = !res_valid || rsp.ready;
  assign gl_wide  = (G_MAX_W+1)'(q_item.gran) + (G_MAX_W+1)'(q_item.count)
                  - (G_MAX_W+1)'(1);

  // Partial masks for the first and last word of a range
  always_comb begin
    ones = '1;
    m_lo = (p_word == w_first) ? b_first : '0;
    m_hi = (p_word == w_last) ? b_last : BIT_W'(WORD_BITS - 1);
    mask = (ones << m_lo) & (ones >> (BIT_W'(WORD_BITS - 1) - m_hi));
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_status = hold.status;
    emit_src    = hold;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    unique case (state)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid && res_free) begin
          q_pop = 1'b1;
          unique case (q_item.act)
            ACT_READ: begin
              mem_re     = 1'b1;
              mem_raddr  = phys(q_item.region, WW'(q_item.gran >> BIT_W));
              state_next = BK_CHECK;
            end
            ACT_WALK: begin
              state_next = BK_WALK;
            end
            default: begin
              emit        = 1'b1;
              emit_status = q_item.status;
              emit_src    = q_item;
            end
          endcase
        end
      end
      BK_CHECK: begin
        emit        = 1'b1;
        emit_status = rd_data[b_first] ? ST_HIT : ST_OK;
        state_next  = BK_IDLE;
      end
      BK_WALK: begin
        if (!issued_all) begin
          mem_re    = 1'b1;
          mem_raddr = phys(hold.region, w_cur);
        end
        if (p_valid) begin
          mem_we    = 1'b1;
          mem_waddr = phys(hold.region, p_word);
          mem_wdata = (hold.func == FN_POISON) ? (rd_data | mask) : (rd_data & ~mask);
          if (issued_all) begin
            emit       = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Walk bookkeeping: read word i while word i-1 is written back
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold       <= q_item;
      b_first    <= q_item.gran[BIT_W-1:0];
      w_first    <= WW'(q_item.gran >> BIT_W);
      w_cur      <= WW'(q_item.gran >> BIT_W);
      w_last     <= WW'(gl_wide >> BIT_W);
      b_last     <= gl_wide[BIT_W-1:0];
      issued_all <= 1'b0;
      p_valid    <= 1'b0;
    end else if (state == BK_WALK) begin
      p_valid <= !issued_all;
      if (!issued_all) begin
        p_word <= w_cur;
        if (w_cur == w_last) begin
          issued_all <= 1'b1;
        end else begin
          w_cur <= w_cur + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.status   <= emit_status;
      res.is_store <= (emit_src.func == FN_STORE);
      res.addr     <= emit_src.addr;
      res.len      <= emit_src.len;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.status        = res.status;
  assign rsp.is_store      = res.is_store;
  assign rsp.fault_address = res.addr;
  assign rsp.fault_length  = res.len;

endmodule

`default_nettype wire

// ===== rtl/core/shadow_bitmap_access_checker.sv =====
// Shadow bitmap access checker: a check needs one shadow read in the back part, which
// takes no new item until the check's result is emitted; other items pass at one per
// cycle while the result register is free; a range walk reads one shadow word per cycle
// (read port bound). Path: front input register, queue, back part, result register.
// Reset (rst, synchronous): regions cleared, loads checked, then a clearing pass
// poisons all REGIONS * SHADOW_WORDS_PER_REGION shadow words (2048 by default),
// during which no item is accepted; configuration writes are taken throughout.
`default_nettype none

module shadow_bitmap_access_checker import sbac_pkg::*; #(
  parameter int REGIONS                 = 2,
  parameter int SHADOW_WORDS_PER_REGION = 1024
) (
  input  logic       clk,
  input  logic       rst,
  sbac_cfg_if.sink   cfg,
  sbac_req_if.sink   req,
  sbac_rsp_if.source rsp
);

  // Bytes covered by one region's shadow; larger sizes are clamped to it
  localparam int CAP = SHADOW_WORDS_PER_REGION * WORD_BITS * GRANULE_BYTES;

  // Configuration registers
  logic [ADDR_W-1:0] base0;
  logic [LEN_W-1:0]  size0;
  logic [ADDR_W-1:0] base1;
  logic [LEN_W-1:0]  size1;
  logic              load_en;
  logic              cfg_wr;

  // Precomputed region end addresses, registered from base and size. Configuration
  // is to be written by the user only while idle, so no item sees a stale end; the block does not enforce this.
  logic [ADDR_W:0]   lim0;
  logic [ADDR_W:0]   lim1;
  region_cfg_t       regions;

  // Front -> queue -> back
  logic              push_valid;
  item_t             push_item;
  logic              push_ready;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic              clearing;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base0   <= '0;
      size0   <= '0;
      base1   <= '0;
      size1   <= '0;
      load_en <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_R0_BASE: base0   <= cfg.data;
        REG_R0_SIZE: size0   <= cfg.data[LEN_W-1:0];
        REG_R1_BASE: base1   <= cfg.data;
        REG_R1_SIZE: size1   <= cfg.data[LEN_W-1:0];
        REG_LOAD_EN: load_en <= cfg.data[0];
        default: ;  // unknown index: write ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim0 <= (ADDR_W+1)'(base0)
          + (((ADDR_W+1)'(size0) > (ADDR_W+1)'(CAP)) ? (ADDR_W+1)'(CAP) : (ADDR_W+1)'(size0));
    lim1 <= (ADDR_W+1)'(base1)
          + (((ADDR_W+1)'(size1) > (ADDR_W+1)'(CAP)) ? (ADDR_W+1)'(CAP) : (ADDR_W+1)'(size1));
  end

  always_comb begin
    regions.base[0] = base0;
    regions.base[1] = base1;
    regions.lim[0]  = lim0;
    regions.lim[1]  = lim1;
    regions.on[0]   = (size0 != '0);   // size zero means unregistered
    regions.on[1]   = (size1 != '0);
    regions.load_en = load_en;
  end

  // Front: input register plus region classification
  sbac_front #(
    .REGIONS (REGIONS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (!clearing),
    .regions    (regions),
    .req        (req),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Two-entry decoupling queue: the front keeps accepting during a long walk until it is full
  sbac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_item   (push_item),
    .in_ready  (push_ready),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_pop   (q_pop)
  );

  // Back: shadow memory, check reads, range walks, result register
  sbac_back #(
    .REGIONS                 (REGIONS),
    .SHADOW_WORDS_PER_REGION (SHADOW_WORDS_PER_REGION)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

  // No item enters while the shadow is being poisoned
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("item input open during clearing pass");

  // Nothing queued while the clearing pass runs
  a_queue_empty_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_valid)
    else $error("queued item during clearing pass");

  // A store check never reports a range status
  a_store_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_store) |-> (rsp.status == ST_OK || rsp.status == ST_HIT))
    else $error("store check reported range status");

endmodule

`default_nettype wire

// ===== test/shadow_bitmap_access_checker_test.sv =====
// Self-checking bench for shadow_bitmap_access_checker: a directed table and then
// random alloc/access/free traffic, checked against an in-bench shadow bitmap predictor.
// Depends on sbac_pkg, the channel interfaces in sbac_ifs.sv and the block itself.
`timescale 1ns / 1ps

module shadow_bitmap_access_checker_test import sbac_pkg::*; ();

  localparam int REGION_COUNT = 2;
  localparam int SHADOW_WORDS = 1024;
  localparam int MAP_DEPTH    = REGION_COUNT * SHADOW_WORDS;
  // Bytes covered by one region's share of the shadow; larger sizes are clamped
  localparam int REGION_CAP   = SHADOW_WORDS * WORD_BITS * GRANULE_BYTES;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int HOLD_AFTER   = 200;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst;

  sbac_cfg_if cfg_ch ();
  sbac_req_if req_ch ();
  sbac_rsp_if rsp_ch ();

  shadow_bitmap_access_checker #(
    .REGIONS                 (REGION_COUNT),
    .SHADOW_WORDS_PER_REGION (SHADOW_WORDS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow bitmap, region windows, load check switch
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0] poison_map [MAP_DEPTH];
  logic [ADDR_W-1:0]    region_start [REGION_COUNT];
  logic [LEN_W-1:0]     region_len [REGION_COUNT];
  logic                 loads_checked;

  result_t verdicts_due [$];   // expected results, oldest first
  int      items_sent;
  int      results_seen;
  int      err_count;
  int      burst_left;

  // Clamped byte span of a region
  function automatic int span(int k);
    return (int'(region_len[k]) > REGION_CAP) ? REGION_CAP : int'(region_len[k]);
  endfunction

  // End of a region, one past its last byte, without wrap
  function automatic logic [ADDR_W:0] region_stop(int k);
    logic [ADDR_W:0] e;
    e = {1'b0, region_start[k]};
    e = e + (ADDR_W+1)'(span(k));
    return e;
  endfunction

  // First region holding the byte, or -1
  function automatic int owner(logic [ADDR_W-1:0] a);
    for (int k = 0; k < REGION_COUNT; k++) begin
      if (region_len[k] != '0 && a >= region_start[k] && {1'b0, a} < region_stop(k))
        return k;
    end
    return -1;
  endfunction

  function automatic void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_R0_BASE: region_start[0] = value;
      REG_R0_SIZE: region_len[0]   = value[LEN_W-1:0];
      REG_R1_BASE: region_start[1] = value;
      REG_R1_SIZE: region_len[1]   = value[LEN_W-1:0];
      REG_LOAD_EN: loads_checked   = value[0];
      default: ;
    endcase
  endfunction

  // Verdict for one item; range operations update the bitmap as they go
  function automatic result_t judge_access(func_t f, logic [ADDR_W-1:0] a,
                                           logic [LEN_W-1:0] l);
    result_t          r;
    logic [ADDR_W-1:0] last;
    int               k;
    int unsigned      g;
    int unsigned      w;
    r.status   = ST_OK;
    r.is_store = (f == FN_STORE);
    r.addr     = a;
    r.len      = l;
    if (f == FN_LOAD || f == FN_STORE) begin
      if (f == FN_STORE || loads_checked) begin
        // only the granule of the last byte counts; zero length wraps to a - 1
        last = a + ADDR_W'(l) - ADDR_W'(1);
        k = owner(last);
        if (k >= 0) begin
          g = (last - region_start[k]) >> GRAN_SH;
          w = k * SHADOW_WORDS + g / WORD_BITS;
          if (w < MAP_DEPTH && poison_map[w][g % WORD_BITS])
            r.status = ST_HIT;
        end
      end
    end else begin
      k = owner(a);
      if (k < 0) begin
        r.status = ST_OUTSIDE;
      end else if ({1'b0, a} + (ADDR_W+1)'(l) > region_stop(k)) begin
        r.status = ST_PAST_END;
      end else begin
        // whole granules only; a trailing partial granule is left alone
        g = (a - region_start[k]) >> GRAN_SH;
        for (int unsigned i = 0; i < (l >> GRAN_SH); i++) begin
          w = k * SHADOW_WORDS + (g + i) / WORD_BITS;
          if (w < MAP_DEPTH)
            poison_map[w][(g + i) % WORD_BITS] = (f == FN_POISON);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows carry a status that is obvious by inspection;
  // the rest go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] value;
    func_t                 func;
    logic [ADDR_W-1:0]     addr;
    logic [LEN_W-1:0]      len;
    logic                  typed;
    status_t               status;
  } plan_row_t;

  localparam logic CFG_ROW   = 1'b1;
  localparam logic ITEM_ROW  = 1'b0;
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam int   PLAN_ROWS = 35;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset state: no region registered
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h0000_1000, 19'h00004, TYPED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'hFFFF_FFFF, 19'h7FFFF, TYPED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_POISON,   32'h0000_0000, 19'h00008, TYPED, ST_OUTSIDE},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_UNPOISON, 32'hFFFF_FFF8, 19'h00001, TYPED, ST_OUTSIDE},
    // one small region low, one that ends exactly at the top of the address space
    '{CFG_ROW, REG_R0_BASE, 32'h0000_1000, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{CFG_ROW, REG_R0_SIZE, 32'h0000_1000, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{CFG_ROW, REG_R1_BASE, 32'hFFFF_F000, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{CFG_ROW, REG_R1_SIZE, 32'h0000_1000, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h0000_1000, 19'h00001, TYPED, ST_HIT},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'h0000_1FFF, 19'h00001, TYPED, ST_HIT},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'h0000_2000, 19'h00001, TYPED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_UNPOISON, 32'h0000_1000, 19'h01000, TYPED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h0000_1000, 19'h00008, PREDICTED, ST_OK},
    // unaligned range: length counts whole granules, so only the start granule changes
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_POISON,   32'h0000_1003, 19'h0000D, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h0000_1008, 19'h00001, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h0000_1004, 19'h00001, PREDICTED, ST_OK},
    // zero length: check probes address - 1, range changes nothing
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'h0000_1000, 19'h00000, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_POISON,   32'h0000_1800, 19'h00000, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_POISON,   32'h0000_1FF8, 19'h00009, TYPED, ST_PAST_END},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_UNPOISON, 32'hFFFF_F000, 19'h01000, TYPED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'hFFFF_FFFF, 19'h00001, PREDICTED, ST_OK},
    // zero length at address 0 wraps to the top byte
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'h0000_0000, 19'h00000, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_POISON,   32'hFFFF_FFF8, 19'h00008, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'h0000_0000, 19'h00000, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_UNPOISON, 32'hFFFF_FFF0, 19'h7FFFF, TYPED, ST_PAST_END},
    // loads unchecked
    '{CFG_ROW, REG_LOAD_EN, 32'h0000_0000, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h0000_1004, 19'h00001, TYPED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_STORE,    32'h0000_1004, 19'h00001, PREDICTED, ST_OK},
    // oversized region gets clamped to the shadow capacity
    '{CFG_ROW, REG_LOAD_EN, 32'h0000_0001, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{CFG_ROW, REG_R0_BASE, 32'h1000_0000, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{CFG_ROW, REG_R0_SIZE, 32'h0007_FFFF, FN_LOAD, 32'h0, 19'h0, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_UNPOISON, 32'h1000_0000, 19'h40000, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h1003_FFFF, 19'h00001, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_LOAD,     32'h1004_0000, 19'h00001, PREDICTED, ST_OK},
    '{ITEM_ROW, REG_R0_BASE, 32'h0, FN_POISON,   32'h1003_FFF8, 19'h00010, TYPED, ST_PAST_END}
  };

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL shadow_bitmap_access_checker");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    set_register(idx, value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Leaves valid high so a following item goes out back to back
  task automatic send_item(func_t f, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l,
                           logic typed, status_t st);
    result_t v;
    req_ch.func    <= f;
    req_ch.address <= a;
    req_ch.length  <= l;
    req_ch.valid   <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    v = judge_access(f, a, l);
    if (typed) v.status = st;
    verdicts_due.push_back(v);
    items_sent++;
    @(negedge clk);
  endtask

  // Sender bursts: mostly short with gaps, now and then a long unbroken run
  task automatic offer(func_t f, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    send_item(f, a, l, PREDICTED, ST_OK);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (verdicts_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return LEN_W'($urandom_range(1, 64));
    if (r < 85) return LEN_W'($urandom_range(0, 1024));
    if (r < 97) return LEN_W'($urandom_range(1, 8192));
    return LEN_W'($urandom_range(0, 19'h7FFFF));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_region_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(8, 4096);
    if (r < 6) return $urandom_range(1, 65536);
    if (r < 8) return REGION_CAP;
    if (r < 9) return $urandom_range(REGION_CAP + 1, 19'h7FFFF);
    return $urandom;   // junk above the size field
  endfunction

  // Anything at all, biased toward the neighborhood of a region
  task automatic noise_item();
    func_t             f;
    logic [ADDR_W-1:0] a;
    int                k;
    f = func_t'($urandom_range(0, 3));
    k = $urandom_range(0, REGION_COUNT - 1);
    if ($urandom_range(0, 1) != 0)
      a = $urandom;
    else
      a = region_start[k] + $urandom_range(0, span(k) + 64) - 32;
    offer(f, a, pick_length());
  endtask

  // Well-formed lifetime of a block: unpoison, a few accesses around it, mostly a free
  task automatic alloc_sequence();
    int                k;
    int                s;
    int                off;
    int                n;
    logic [ADDR_W-1:0] a;
    logic [LEN_W-1:0]  sz;
    k = $urandom_range(0, REGION_COUNT - 1);
    if (region_len[k] == '0) k = 1 - k;
    s = span(k);
    if (s < GRANULE_BYTES) begin
      noise_item();
      return;
    end
    off = $urandom_range(0, s - 1);
    if ($urandom_range(0, 3) != 0) off = off & ~(GRANULE_BYTES - 1);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, s - off) : $urandom_range(1, 256);
    a = region_start[k] + off;
    offer(FN_UNPOISON, a, LEN_W'(n));
    repeat ($urandom_range(2, 8)) begin
      sz = ($urandom_range(0, 15) == 0) ? '0 : LEN_W'(1 << $urandom_range(0, 4));
      offer($urandom_range(0, 1) ? FN_STORE : FN_LOAD, a + $urandom_range(0, n + 15) - 8, sz);
    end
    if ($urandom_range(0, 9) < 7) offer(FN_POISON, a, LEN_W'(n));
  endtask

  // New region layout for a phase; the first three are set up as corner layouts
  task automatic configure_phase(int p);
    logic [CFG_DATA_W-1:0] b0;
    logic [CFG_DATA_W-1:0] b1;
    logic [CFG_DATA_W-1:0] s0;
    logic [CFG_DATA_W-1:0] s1;
    logic                  le;
    b0 = $urandom;
    b1 = $urandom;
    s0 = pick_region_size();
    s1 = pick_region_size();
    le = ($urandom_range(0, 3) != 0);
    case (p)
      0: begin
        // full-capacity region at 0, clamped region ending at the top
        b0 = '0;
        s0 = REGION_CAP;
        b1 = 32'hFFFC_0000;
        s1 = 32'hFFFF_FFFF;
      end
      1: begin
        s0 = '0;
        le = 1'b0;
      end
      2: begin
        // overlapping windows, region 0 wins where both match
        b1 = b0 + 1024;
        s0 = 2048;
        s1 = 4096;
      end
      default: ;
    endcase
    write_reg(REG_R0_BASE, b0);
    write_reg(REG_R0_SIZE, s0);
    write_reg(REG_R1_BASE, b1);
    write_reg(REG_R1_SIZE, s1);
    write_reg(REG_LOAD_EN, ($urandom & 32'hFFFF_FFFE) | CFG_DATA_W'(le));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_R0_BASE;
    cfg_ch.data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.func    = FN_LOAD;
    req_ch.address = '0;
    req_ch.length  = '0;
    items_sent     = 0;
    results_seen   = 0;
    err_count      = 0;
    burst_left     = 0;

    // predictor after reset: everything poisoned, no regions, loads checked
    foreach (poison_map[i]) poison_map[i] = '1;
    foreach (region_start[k]) begin
      region_start[k] = '0;
      region_len[k]   = '0;
    end
    loads_checked = 1'b1;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed table; the block takes no item until its clearing pass is done
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].is_cfg) begin
        drain();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else begin
        send_item(PLAN[i].func, PLAN[i].addr, PLAN[i].len, PLAN[i].typed, PLAN[i].status);
      end
    end

    // random phases; each starts idle with a fresh register set
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure_phase(p);
      while (items_sent < PLAN_ROWS + (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7)
          alloc_sequence();
        else
          noise_item();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (err_count == 0 && verdicts_due.size() == 0)
      $display("PASS shadow_bitmap_access_checker");
    else
      $display("FAIL shadow_bitmap_access_checker");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: changing stall modes, plus one long hold once traffic is going,
  // long enough for the block to back up and stall the item channel.
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    int   hold_left;
    int   mode;
    int   mode_left;
    int   pat_pos;
    logic hold_done;
    rsp_ch.ready = 1'b0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    pat_pos   = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
          default: begin
            // fixed duty: 3 ready out of 7
            pat_pos = (pat_pos + 1) % 7;
            rsp_ch.ready <= (pat_pos < 3);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("result %0d with nothing expected: status %0d addr %h len %h",
                   results_seen, rsp_ch.status, rsp_ch.fault_address, rsp_ch.fault_length);
      end else begin
        want = verdicts_due.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.is_store !== want.is_store ||
            rsp_ch.fault_address !== want.addr || rsp_ch.fault_length !== want.len) begin
          err_count++;
          if (err_count <= 10)
            $display("result %0d mismatch: status %0d/%0d store %0b/%0b addr %h/%h len %h/%h",
                     results_seen, want.status, rsp_ch.status, want.is_store,
                     rsp_ch.is_store, want.addr, rsp_ch.fault_address, want.len,
                     rsp_ch.fault_length);
        end
      end
    end
  end

endmodule
